// File: rtl/pbsa_pkg.sv
// Shared types, constants and the quarter-sine table of the pop-bounce scale animator.
`timescale 1ns / 1ps

package pbsa_pkg;

  // Width of the sine table index; the table holds 2^SINE_INDEX_BITS + 1 entries.
  localparam int unsigned SINE_INDEX_BITS = 8;
  localparam int unsigned SINE_ROM_SIZE   = (1 << SINE_INDEX_BITS) + 1;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned EASED_W = 17;
  localparam int unsigned DIV_STEPS = DATA_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [DATA_W-1:0] SCALE_ONE       = 16'd16384;
  localparam logic [DATA_W-1:0] GROW_TIME_RST   = 16'd300;
  localparam logic [DATA_W-1:0] POP_TIME_RST    = 16'd150;
  localparam logic [DATA_W-1:0] POP_SCALE_RST   = 16'd19661;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SERIES_DIVS [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_GROW   = 2'd1,
    PH_POP    = 2'd2,
    PH_SETTLE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_START  = 2'd1,
    CMD_BOUNCE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_GROW_TIME = 2'd0,
    CFG_POP_TIME  = 2'd1,
    CFG_POP_SCALE = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROM,
    ST_MUL,
    ST_DONE
  } state_e;

  // Control strobes from the sequencer to the datapath.
  typedef struct packed {
    logic in_ready;
    logic div_start;
    logic rom_en;
    logic mul_en;
    logic commit;
  } ctrl_t;

  // Status seen by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic need_div;
    logic div_done;
    logic out_free;
  } stat_t;

  typedef logic [EASED_W-1:0] sine_rom_t [SINE_ROM_SIZE];

  // Evaluated at elaboration: sin by a fixed-point Taylor series in Q30, rounded to Q1.16.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    for (int unsigned i = 0; i < SINE_ROM_SIZE; i++) begin
      x  = (64'(i) * HALF_PI_Q30) >> SINE_INDEX_BITS;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (int unsigned k = 0; k < 5; k++) begin
        t = Q30_ONE - ((x2 * t) >> 30) / SERIES_DIVS[k];
      end
      s = (x * t) >> 30;
      s = (s + 64'd8192) >> 14;
      if (s > 64'd65536) begin
        s = 64'd65536;
      end
      rom[i] = EASED_W'(s);
    end
    rom[0]               = '0;
    rom[SINE_ROM_SIZE-1] = EASED_W'(65536);
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// File: rtl/pbsa_div.sv
// Bit-serial restoring divider forming the 16 fraction bits of elapsed / duration.
`timescale 1ns / 1ps

module pbsa_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pbsa_pkg::DATA_W-1:0]   num_i,
  input  logic [pbsa_pkg::DATA_W-1:0]   den_i,
  output logic                          done_o,
  output logic [pbsa_pkg::DATA_W-1:0]   quot_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [pbsa_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [pbsa_pkg::DATA_W-1:0]      rem_q, rem_d;
  logic [pbsa_pkg::DATA_W-1:0]      den_q, den_d;
  logic [pbsa_pkg::DATA_W-1:0]      quo_q, quo_d;
  logic [pbsa_pkg::DATA_W:0]        shifted;
  logic [pbsa_pkg::DATA_W:0]        diff;
  logic                             fits;

  // The numerator is always below the divisor, so the quotient is a pure fraction.
  assign shifted = {rem_q, 1'b0};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = pbsa_pkg::DIV_CNT_W'(pbsa_pkg::DIV_STEPS - 1);
      rem_d  = num_i;
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? diff[pbsa_pkg::DATA_W-1:0] : shifted[pbsa_pkg::DATA_W-1:0];
      quo_d = {quo_q[pbsa_pkg::DATA_W-2:0], fits};
      cnt_d = cnt_q - pbsa_pkg::DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: rtl/pbsa_ctrl.sv
// Sequencer that steps one item through divide, table look-up, multiply and commit, or straight to commit.
`timescale 1ns / 1ps

module pbsa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pbsa_pkg::stat_t stat_i,
  output pbsa_pkg::ctrl_t ctrl_o
);

  pbsa_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pbsa_pkg::ST_IDLE: begin
        if (stat_i.in_valid) begin
          state_d = stat_i.need_div ? pbsa_pkg::ST_DIV : pbsa_pkg::ST_DONE;
        end
      end
      pbsa_pkg::ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = pbsa_pkg::ST_ROM;
        end
      end
      pbsa_pkg::ST_ROM: state_d = pbsa_pkg::ST_MUL;
      pbsa_pkg::ST_MUL: state_d = pbsa_pkg::ST_DONE;
      pbsa_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = pbsa_pkg::ST_IDLE;
        end
      end
      default: state_d = pbsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      pbsa_pkg::ST_IDLE: begin
        ctrl_o.in_ready  = 1'b1;
        ctrl_o.div_start = stat_i.in_valid && stat_i.need_div;
      end
      pbsa_pkg::ST_DIV: ;
      pbsa_pkg::ST_ROM:  ctrl_o.rom_en = 1'b1;
      pbsa_pkg::ST_MUL:  ctrl_o.mul_en = 1'b1;
      pbsa_pkg::ST_DONE: ctrl_o.commit = stat_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbsa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/pop_bounce_scale_animator_unit.sv
// Top level of the pop-bounce scale animator: state, configuration, datapath and output word.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------
//   in      | input     | in_valid_i / in_ready_o | in_cmd_i, in_delta_time_i
//   out     | output    | out_valid_o/out_ready_i | out_scale_o, out_phase_o, out_finished_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A tick inside an active phase that does not end it passes from acceptance to the result
// word through the bit-serial divider, its done flag register, the sine table read, the
// multiply and the commit. Every other word goes from acceptance straight to the commit.
// The input is ready again in the cycle after each commit.
// Reset restores the register defaults, idle phase and unit scale; no clearing pass.
// A result waits in the output register while the next word is already accepted; only the
// commit stalls on a full output register.
`timescale 1ns / 1ps

module pop_bounce_scale_animator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   in_cmd_i,
  input  logic [pbsa_pkg::DATA_W-1:0]  in_delta_time_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [pbsa_pkg::DATA_W-1:0]  out_scale_o,
  output logic [1:0]                   out_phase_o,
  output logic                         out_finished_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [pbsa_pkg::DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned W = pbsa_pkg::DATA_W;

  pbsa_pkg::ctrl_t  ctrl;
  pbsa_pkg::stat_t  stat;

  logic [W-1:0] grow_time_q, pop_time_q, pop_scale_q;

  pbsa_pkg::phase_e phase_q, phase_d;
  logic [W-1:0]     elapsed_q, elapsed_d;
  logic [W-1:0]     scale_q, scale_d;

  pbsa_pkg::cmd_e   cmd_q;
  logic [W-1:0]     el_sat_q;
  logic             reached_q;
  logic [pbsa_pkg::EASED_W-1:0] eased_q;
  logic [W-1:0]     part_q;

  logic             out_valid_q;
  logic [W-1:0]     out_scale_q;
  pbsa_pkg::phase_e out_phase_q;

  logic [W-1:0]     dur, start_s, target_s;
  logic [W:0]       sum;
  logic [W-1:0]     el_sat;
  logic             accept;
  logic             div_done;
  logic [W-1:0]     quot;
  logic signed [W:0]    span;
  logic signed [pbsa_pkg::EASED_W+W+1:0] prod;

  // Phase table: duration, start and target of the current phase.
  always_comb begin
    unique case (phase_q)
      pbsa_pkg::PH_GROW: begin
        dur = grow_time_q;  start_s = '0;              target_s = pbsa_pkg::SCALE_ONE;
      end
      pbsa_pkg::PH_POP: begin
        dur = pop_time_q;   start_s = pbsa_pkg::SCALE_ONE; target_s = pop_scale_q;
      end
      pbsa_pkg::PH_SETTLE: begin
        dur = pop_time_q;   start_s = pop_scale_q;     target_s = pbsa_pkg::SCALE_ONE;
      end
      default: begin
        dur = '0;           start_s = pbsa_pkg::SCALE_ONE; target_s = pbsa_pkg::SCALE_ONE;
      end
    endcase
  end

  assign sum    = {1'b0, elapsed_q} + {1'b0, in_delta_time_i};
  assign el_sat = (sum > {1'b0, dur}) ? dur : sum[W-1:0];
  assign accept = in_valid_i && ctrl.in_ready;

  // The phase ends exactly when elapsed reaches the duration; no division is then needed.
  assign stat.in_valid = in_valid_i;
  assign stat.need_div = (in_cmd_i == pbsa_pkg::CMD_TICK) && (phase_q != pbsa_pkg::PH_IDLE)
                         && (el_sat != dur);
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_q || out_ready_i;

  pbsa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  pbsa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.div_start),
    .num_i   (el_sat),
    .den_i   (dur),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign span = $signed({1'b0, target_s}) - $signed({1'b0, start_s});
  assign prod = span * $signed({1'b0, eased_q});

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= pbsa_pkg::cmd_e'(in_cmd_i);
      el_sat_q  <= el_sat;
      reached_q <= (el_sat == dur);
    end
    if (ctrl.rom_en) begin
      eased_q <= pbsa_pkg::SINE_ROM[{1'b0, quot[W-1 -: pbsa_pkg::SINE_INDEX_BITS]}];
    end
    // Arithmetic shift floors, so only the low 16 bits of the shifted product matter.
    if (ctrl.mul_en) begin
      part_q <= prod[2*W-1:W];
    end
  end

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    scale_d   = scale_q;
    unique case (cmd_q)
      pbsa_pkg::CMD_TICK: begin
        if (phase_q != pbsa_pkg::PH_IDLE) begin
          if (reached_q) begin
            elapsed_d = '0;
            scale_d   = target_s;
            unique case (phase_q)
              pbsa_pkg::PH_GROW: phase_d = pbsa_pkg::PH_POP;
              pbsa_pkg::PH_POP:  phase_d = pbsa_pkg::PH_SETTLE;
              default:           phase_d = pbsa_pkg::PH_IDLE;
            endcase
          end else begin
            elapsed_d = el_sat_q;
            scale_d   = start_s + part_q;
          end
        end
      end
      pbsa_pkg::CMD_START: begin
        phase_d   = pbsa_pkg::PH_GROW;
        elapsed_d = '0;
        scale_d   = '0;
      end
      pbsa_pkg::CMD_BOUNCE: begin
        if (phase_q == pbsa_pkg::PH_IDLE) begin
          phase_d   = pbsa_pkg::PH_POP;
          elapsed_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= pbsa_pkg::PH_IDLE;
      elapsed_q   <= '0;
      scale_q     <= pbsa_pkg::SCALE_ONE;
      out_valid_q <= 1'b0;
      grow_time_q <= pbsa_pkg::GROW_TIME_RST;
      pop_time_q  <= pbsa_pkg::POP_TIME_RST;
      pop_scale_q <= pbsa_pkg::POP_SCALE_RST;
    end else begin
      if (ctrl.commit) begin
        phase_q     <= phase_d;
        elapsed_q   <= elapsed_d;
        scale_q     <= scale_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (pbsa_pkg::cfg_idx_e'(cfg_index_i))
          pbsa_pkg::CFG_GROW_TIME: grow_time_q <= cfg_data_i;
          pbsa_pkg::CFG_POP_TIME:  pop_time_q  <= cfg_data_i;
          pbsa_pkg::CFG_POP_SCALE: pop_scale_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      out_scale_q <= scale_d;
      out_phase_q <= phase_d;
    end
  end

  assign in_ready_o     = ctrl.in_ready;
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign out_scale_o    = out_scale_q;
  assign out_phase_o    = out_phase_q;
  assign out_finished_o = (out_phase_q == pbsa_pkg::PH_IDLE);

endmodule

// File: rtl/pbsa_checker.sv
// Port-level checker for the pop-bounce scale animator, bound to its top level.
`timescale 1ns / 1ps

module pbsa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [pbsa_pkg::DATA_W-1:0]  out_scale_o,
  input logic [1:0]                   out_phase_o,
  input logic                         out_finished_o
);

  // A result word is held until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_scale_o)
                                    && $stable(out_phase_o))
    else $error("result word changed or dropped while stalled");

  // Only one word is in work at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  a_finished_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_finished_o == (out_phase_o == pbsa_pkg::PH_IDLE))
    else $error("finished flag disagrees with phase");

  // The idle phase always rests at unit scale.
  a_idle_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_finished_o |-> out_scale_o == pbsa_pkg::SCALE_ONE)
    else $error("idle result not at unit scale");

endmodule

bind pop_bounce_scale_animator_unit pbsa_checker u_pbsa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_scale_o    (out_scale_o),
  .out_phase_o    (out_phase_o),
  .out_finished_o (out_finished_o)
);
